@@ rtl/vdi_pkg.sv @@
// Shared definitions for the vertex deduplication indexer.
// Holds sizes, codes, the controller state type and the ctrl/datapath bundles.
// No dependencies.
package vdi_pkg;

	// Default sizing, handed to the top-level parameters
	localparam int MAX_UNIQUE_DEF       = 1024;
	localparam int MAX_VERTEX_WORDS_DEF = 8;

	// Fixed field widths
	localparam int INDEX_W = 10;
	localparam int CHUNK_W = 64;
	localparam int VB_W    = 7;

	// Register file
	localparam int              APB_AW           = 3;
	localparam int              APB_DW           = 32;
	localparam logic [VB_W-1:0] VB_RESET         = 7'd32;
	localparam logic            REG_VERTEX_BYTES = 1'b0;  // register index, paddr[2]

	// Input item kinds
	localparam logic KIND_CHUNK = 1'b0;
	localparam logic KIND_START = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_APPEND,
		ST_RESP
	} vdi_state_t;

	// Controller -> datapath
	typedef struct packed {
		logic take;        // input transfer this cycle
		logic scan_start;  // arm the table scan
		logic scan_run;    // scan pointers advance
		logic set_hit;     // latch a match result
		logic set_new;     // latch an append result, arm the append writer
		logic set_full;    // latch an overflow result
		logic append;      // write one word of the new entry
		logic out_load;    // move the result into the output register
	} vdi_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic last_chunk;   // current input chunk completes a vertex
		logic empty;        // no unique vertex stored
		logic full;         // table holds MAX_UNIQUE vertices
		logic hit;          // last word of a slot matched on every word
		logic miss;         // last slot finished with no match
		logic append_last;  // final word of the new entry is being written
		logic out_free;     // output register can take a result
	} vdi_stat_t;

endpackage

@@ rtl/vertex_dedup_indexer.sv @@
// Vertex deduplication indexer: a non-final chunk or a start item is taken while idle.
// A final chunk is accepted, then on a non-empty table the store is scanned (S stored
// vertices, W = ceil(vertex_bytes/8) words each, one store read per cycle) up to the
// first match; on an append MAX_VERTEX_WORDS words are written; then the result is loaded
// (held while the output is stalled); the next item is taken after the load.
// Reset (arst_n low) empties the table, drops partial vertices, sets size 32.
module vertex_dedup_indexer #(
	parameter int MAX_UNIQUE       = vdi_pkg::MAX_UNIQUE_DEF,
	parameter int MAX_VERTEX_WORDS = vdi_pkg::MAX_VERTEX_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// Configuration port
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [vdi_pkg::APB_AW-1:0]       paddr,
	input  logic [vdi_pkg::APB_DW-1:0]       pwdata,
	output logic [vdi_pkg::APB_DW-1:0]       prdata,
	output logic                             pready,
	// Input channel
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [vdi_pkg::CHUNK_W-1:0]      chunk,
	// Output channel
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [vdi_pkg::INDEX_W-1:0]      vertex_index,
	output logic                             is_new,
	output logic                             table_full
);

	logic [vdi_pkg::VB_W-1:0] vertex_bytes;
	logic                     cfg_wr;
	vdi_pkg::vdi_cmd_t        cmd;
	vdi_pkg::vdi_stat_t       stat;

	// Register file
	vdi_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.vertex_bytes(vertex_bytes),
		.cfg_wr      (cfg_wr)
	);

	// Sequencer
	vdi_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.stat    (stat),
		.cmd     (cmd)
	);

	// Datapath
	vdi_dpath #(
		.MAX_UNIQUE      (MAX_UNIQUE),
		.MAX_VERTEX_WORDS(MAX_VERTEX_WORDS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.kind        (kind),
		.chunk       (chunk),
		.vertex_bytes(vertex_bytes),
		.cfg_wr      (cfg_wr),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.vertex_index(vertex_index),
		.is_new      (is_new),
		.table_full  (table_full)
	);

endmodule

@@ rtl/vdi_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module vdi_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 8192
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/vdi_regs.sv @@
// APB-style register file holding the vertex size register.
// Depends on vdi_pkg.
module vdi_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [vdi_pkg::APB_AW-1:0]     paddr,
	input  logic [vdi_pkg::APB_DW-1:0]     pwdata,
	output logic [vdi_pkg::APB_DW-1:0]     prdata,
	output logic                           pready,
	output logic [vdi_pkg::VB_W-1:0]       vertex_bytes,
	output logic                           cfg_wr
);

	logic [vdi_pkg::VB_W-1:0] vb_q;
	logic                     sel_vb;

	assign pready = 1'b1;
	assign sel_vb = (paddr[2] == vdi_pkg::REG_VERTEX_BYTES);

	// Write strobe on the access phase
	assign cfg_wr = psel && penable && pwrite && pready && sel_vb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vb_q <= vdi_pkg::VB_RESET;
		end else if (cfg_wr) begin
			vb_q <= pwdata[vdi_pkg::VB_W-1:0];
		end
	end

	// Read mux
	assign prdata       = sel_vb ? vdi_pkg::APB_DW'(vb_q) : '0;
	assign vertex_bytes = vb_q;

endmodule

@@ rtl/vdi_ctrl.sv @@
// Controller FSM for the vertex deduplication indexer: sequences assembly,
// table scan, append and result hand-off. Depends on vdi_pkg.
module vdi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  vdi_pkg::vdi_stat_t stat,
	output vdi_pkg::vdi_cmd_t  cmd
);

	vdi_pkg::vdi_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vdi_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			vdi_pkg::ST_IDLE: begin
				if (in_valid && stat.last_chunk) begin
					state_nxt = stat.empty ? vdi_pkg::ST_APPEND : vdi_pkg::ST_SEARCH;
				end
			end
			vdi_pkg::ST_SEARCH: begin
				if (stat.hit) begin
					state_nxt = vdi_pkg::ST_RESP;
				end else if (stat.miss) begin
					state_nxt = stat.full ? vdi_pkg::ST_RESP : vdi_pkg::ST_APPEND;
				end
			end
			vdi_pkg::ST_APPEND: begin
				if (stat.append_last) begin
					state_nxt = vdi_pkg::ST_RESP;
				end
			end
			vdi_pkg::ST_RESP: begin
				if (stat.out_free) begin
					state_nxt = vdi_pkg::ST_IDLE;
				end
			end
			default: state_nxt = vdi_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			vdi_pkg::ST_IDLE: begin
				in_stall       = 1'b0;
				cmd.take       = in_valid;
				cmd.scan_start = in_valid && stat.last_chunk && !stat.empty;
				cmd.set_new    = in_valid && stat.last_chunk && stat.empty;
			end
			vdi_pkg::ST_SEARCH: begin
				cmd.scan_run = 1'b1;
				cmd.set_hit  = stat.hit;
				cmd.set_full = !stat.hit && stat.miss && stat.full;
				cmd.set_new  = !stat.hit && stat.miss && !stat.full;
			end
			vdi_pkg::ST_APPEND: begin
				cmd.append = 1'b1;
			end
			vdi_pkg::ST_RESP: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd      = '0;
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

@@ rtl/vdi_dpath.sv @@
// Datapath: chunk assembly buffer, unique-vertex store, pipelined scan
// compare, append writer and output register. Depends on vdi_pkg, vdi_ram.
module vdi_dpath #(
	parameter int MAX_UNIQUE       = vdi_pkg::MAX_UNIQUE_DEF,
	parameter int MAX_VERTEX_WORDS = vdi_pkg::MAX_VERTEX_WORDS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  vdi_pkg::vdi_cmd_t                cmd,
	output vdi_pkg::vdi_stat_t               stat,
	input  logic                             kind,
	input  logic [vdi_pkg::CHUNK_W-1:0]      chunk,
	input  logic [vdi_pkg::VB_W-1:0]         vertex_bytes,
	input  logic                             cfg_wr,
	input  logic                             out_stall,
	output logic                             out_valid,
	output logic [vdi_pkg::INDEX_W-1:0]      vertex_index,
	output logic                             is_new,
	output logic                             table_full
);

	localparam int IW = $clog2(MAX_UNIQUE);
	localparam int CW = $clog2(MAX_UNIQUE + 1);
	localparam int WW = (MAX_VERTEX_WORDS > 1) ? $clog2(MAX_VERTEX_WORDS) : 1;
	localparam int NW = WW + 1;
	localparam int AW = IW + WW;
	localparam logic [7:0]    MAX_BYTES = 8'(MAX_VERTEX_WORDS * 8);
	localparam logic [CW-1:0] FULL_CNT  = CW'(MAX_UNIQUE);
	localparam logic [WW-1:0] LAST_WORD = WW'(MAX_VERTEX_WORDS - 1);

	// ---------------- vertex size decode ----------------
	logic [7:0]    eff_bytes;
	logic [8:0]    bytes_up;
	logic [NW-1:0] words;
	logic [WW-1:0] wlast;
	logic [2:0]    rem;

	always_comb begin
		if (vertex_bytes == '0) begin
			eff_bytes = 8'd1;
		end else if ({1'b0, vertex_bytes} > MAX_BYTES) begin
			eff_bytes = MAX_BYTES;
		end else begin
			eff_bytes = {1'b0, vertex_bytes};
		end
	end

	assign bytes_up = {1'b0, eff_bytes} + 9'd7;
	assign words    = NW'(bytes_up >> 3);
	assign wlast    = WW'(words - 1'b1);
	assign rem      = eff_bytes[2:0];

	// ---------------- chunk assembly ----------------
	logic [vdi_pkg::CHUNK_W-1:0] asm_q [MAX_VERTEX_WORDS];
	logic [WW-1:0]               cnt_q;
	logic [WW-1:0]               cnt_eff;
	logic                        is_last;
	logic [vdi_pkg::CHUNK_W-1:0] keep_mask;
	logic [vdi_pkg::CHUNK_W-1:0] chunk_wr;
	logic                        take_chunk;

	assign cnt_eff    = ({1'b0, cnt_q} >= words) ? '0 : cnt_q;
	assign is_last    = (cnt_eff == wlast);
	assign take_chunk = cmd.take && (kind == vdi_pkg::KIND_CHUNK);

	// Clear unused high bytes of the final chunk
	always_comb begin
		for (int b = 0; b < 8; b++) begin
			keep_mask[b*8 +: 8] = ((rem == 3'd0) || (3'(b) < rem)) ? 8'hFF : 8'h00;
		end
	end

	assign chunk_wr = is_last ? (chunk & keep_mask) : chunk;

	always_ff @(posedge clk) begin
		if (take_chunk) begin
			asm_q[cnt_eff] <= chunk_wr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cfg_wr) begin
			cnt_q <= '0;
		end else if (cmd.take) begin
			if (kind == vdi_pkg::KIND_START || is_last) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_eff + 1'b1;
			end
		end
	end

	// ---------------- unique count ----------------
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_m1;
	logic [WW-1:0] aw_q;
	logic          append_last;

	assign append_last = (aw_q == LAST_WORD);
	assign count_m1    = count_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.take && kind == vdi_pkg::KIND_START) begin
			count_q <= '0;
		end else if (cmd.append && append_last) begin
			count_q <= count_q + 1'b1;
		end
	end

	// ---------------- scan address generator ----------------
	logic [IW-1:0] slot_q;
	logic [WW-1:0] word_q;
	logic          issue_q;
	logic          slot_end;
	logic          word_end;

	assign word_end = (word_q == wlast);
	assign slot_end = (CW'(slot_q) == count_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q <= 1'b0;
			slot_q  <= '0;
			word_q  <= '0;
		end else if (cmd.scan_start) begin
			issue_q <= 1'b1;
			slot_q  <= '0;
			word_q  <= '0;
		end else if (cmd.scan_run && issue_q) begin
			if (word_end) begin
				word_q <= '0;
				if (slot_end) begin
					issue_q <= 1'b0;
				end else begin
					slot_q <= slot_q + 1'b1;
				end
			end else begin
				word_q <= word_q + 1'b1;
			end
		end
	end

	// Read-stage tags, aligned with the registered RAM data
	logic          valid_s1;
	logic          last_s1;
	logic          final_s1;
	logic [IW-1:0] slot_s1;
	logic [WW-1:0] word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd.scan_run && issue_q;
		end
	end

	always_ff @(posedge clk) begin
		last_s1  <= word_end;
		final_s1 <= word_end && slot_end;
		slot_s1  <= slot_q;
		word_s1  <= word_q;
	end

	// ---------------- unique-vertex store ----------------
	logic [AW-1:0]               waddr;
	logic [AW-1:0]               raddr;
	logic [vdi_pkg::CHUNK_W-1:0] wdata;
	logic [vdi_pkg::CHUNK_W-1:0] rdata;
	logic [WW-1:0]               asm_idx;
	logic [vdi_pkg::CHUNK_W-1:0] asm_word;

	// One shared read of the assembly buffer: append writer or compare stage
	assign asm_idx  = cmd.append ? aw_q : word_s1;
	assign asm_word = asm_q[asm_idx];

	assign waddr = {count_q[IW-1:0], aw_q};
	assign raddr = {slot_q, word_q};
	// Words past the vertex size are stored as zero
	assign wdata = ({1'b0, aw_q} < words) ? asm_word : '0;

	vdi_ram #(
		.WIDTH(vdi_pkg::CHUNK_W),
		.DEPTH(MAX_UNIQUE * (2 ** WW))
	) u_store (
		.clk  (clk),
		.we   (cmd.append),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// ---------------- compare ----------------
	logic match_q;
	logic word_eq;
	logic slot_eq;

	assign word_eq = (rdata == asm_word);
	assign slot_eq = match_q && word_eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b1;
		end else if (cmd.scan_start) begin
			match_q <= 1'b1;
		end else if (valid_s1) begin
			match_q <= last_s1 ? 1'b1 : slot_eq;
		end
	end

	// ---------------- append writer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			aw_q <= '0;
		end else if (cmd.set_new) begin
			aw_q <= '0;
		end else if (cmd.append && !append_last) begin
			aw_q <= aw_q + 1'b1;
		end
	end

	// ---------------- result and output registers ----------------
	logic [IW-1:0] res_idx_q;
	logic          res_new_q;
	logic          res_full_q;
	logic [IW-1:0] out_idx_q;
	logic          out_new_q;
	logic          out_full_q;
	logic          out_valid_q;
	logic [IW+vdi_pkg::INDEX_W-1:0] idx_ext;

	always_ff @(posedge clk) begin
		if (cmd.set_hit) begin
			res_idx_q  <= slot_s1;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b0;
		end else if (cmd.set_new) begin
			res_idx_q  <= count_q[IW-1:0];
			res_new_q  <= 1'b1;
			res_full_q <= 1'b0;
		end else if (cmd.set_full) begin
			res_idx_q  <= '0;
			res_new_q  <= 1'b0;
			res_full_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_idx_q  <= res_idx_q;
			out_new_q  <= res_new_q;
			out_full_q <= res_full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign idx_ext      = {{vdi_pkg::INDEX_W{1'b0}}, out_idx_q};
	assign vertex_index = idx_ext[vdi_pkg::INDEX_W-1:0];
	assign is_new       = out_new_q;
	assign table_full   = out_full_q;
	assign out_valid    = out_valid_q;

	// ---------------- status ----------------
	always_comb begin
		stat             = '0;
		stat.last_chunk  = (kind == vdi_pkg::KIND_CHUNK) && is_last;
		stat.empty       = (count_q == '0);
		stat.full        = (count_q == FULL_CNT);
		stat.hit         = valid_s1 && last_s1 && slot_eq;
		stat.miss        = valid_s1 && final_s1 && !slot_eq;
		stat.append_last = append_last;
		stat.out_free    = !out_valid_q || !out_stall;
	end

	// ---------------- assertions ----------------
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT)
		else $error("unique count beyond table size");

	a_append_bump: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.append && append_last) |=> (count_q == CW'($past(count_q) + 1'b1)))
		else $error("append did not advance unique count");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (CW'(slot_s1) < count_q))
		else $error("scan read a slot beyond the stored vertices");

	a_new_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.set_new |-> (count_q != FULL_CNT))
		else $error("append started on a full table");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result loaded over a pending transfer");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for vertex_dedup_indexer: drives vertex chunks and start items,
// predicts each weld result and compares it with the output channel.
// Depends on rtl/vdi_pkg.sv and rtl/vertex_dedup_indexer.sv.
`timescale 1ns / 1ps

module tb;

	localparam int NU          = vdi_pkg::MAX_UNIQUE_DEF;
	localparam int NW          = vdi_pkg::MAX_VERTEX_WORDS_DEF;
	localparam int VBW         = vdi_pkg::VB_W;
	localparam int QUIET_LIMIT = 100000;  // well above the longest scan
	localparam int TAIL        = 16;
	localparam logic [vdi_pkg::APB_AW-1:0] VB_ADDR = {vdi_pkg::REG_VERTEX_BYTES, 2'b00};

	typedef struct packed {
		logic                        kind_bit;
		logic [vdi_pkg::CHUNK_W-1:0] data;
	} feed_t;

	typedef struct packed {
		logic [vdi_pkg::INDEX_W-1:0] index;
		logic                        fresh;
		logic                        overflow;
	} weld_t;

	logic                        clk       = 1'b0;
	logic                        arst_n    = 1'b0;
	logic                        psel      = 1'b0;
	logic                        penable   = 1'b0;
	logic                        pwrite    = 1'b0;
	logic [vdi_pkg::APB_AW-1:0]  paddr     = '0;
	logic [vdi_pkg::APB_DW-1:0]  pwdata    = '0;
	logic [vdi_pkg::APB_DW-1:0]  prdata;
	logic                        pready;
	logic                        in_valid  = 1'b0;
	logic                        in_stall;
	logic                        kind      = vdi_pkg::KIND_CHUNK;
	logic [vdi_pkg::CHUNK_W-1:0] chunk     = '0;
	logic                        out_valid;
	logic                        out_stall = 1'b0;
	logic [vdi_pkg::INDEX_W-1:0] vertex_index;
	logic                        is_new;
	logic                        table_full;

	vertex_dedup_indexer dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .chunk(chunk),
		.out_valid(out_valid), .out_stall(out_stall),
		.vertex_index(vertex_index), .is_new(is_new), .table_full(table_full)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stimulus and expectations
	feed_t chunk_feed[$];
	weld_t expected_welds[$];
	int idle_pct  = 0;
	int stall_pct = 0;
	bit in_taken  = 1'b0;
	int quiet     = 0;
	int n_fail    = 0;
	int n_taken   = 0;
	int n_checked = 0;
	int n_new     = 0;
	int n_hit     = 0;
	int n_full    = 0;
	logic [VBW-1:0] size_now = vdi_pkg::VB_RESET;

	// Predictor state
	logic [vdi_pkg::CHUNK_W-1:0] uniq_tbl [NU][NW];
	logic [vdi_pkg::CHUNK_W-1:0] asm_buf [NW];
	int                          tbl_cnt    = 0;
	int                          asm_pos    = 0;
	logic [VBW-1:0]              cfg_vbytes = vdi_pkg::VB_RESET;

	// Queue appends
	function automatic void feed_add(input feed_t f);
		chunk_feed = {chunk_feed, f};
	endfunction

	function automatic void weld_add(input weld_t r);
		expected_welds = {expected_welds, r};
	endfunction

	// Size zero acts as one byte, sizes past the widest vertex are clamped
	function automatic int eff_bytes(input logic [VBW-1:0] vb);
		int b;
		b = int'(vb);
		if (b == 0)
			b = 1;
		if (b > 8 * NW)
			b = 8 * NW;
		return b;
	endfunction

	// Assemble chunks; on the last one search the table, then append or flag overflow
	function automatic void weld_vertex_item(input logic k,
		input logic [vdi_pkg::CHUNK_W-1:0] d);
		int b, words, rem, j, w;
		logic same, found;
		logic [vdi_pkg::CHUNK_W-1:0] word;
		weld_t r;
		if (k == vdi_pkg::KIND_START) begin
			tbl_cnt = 0;
			asm_pos = 0;
			return;
		end
		b     = eff_bytes(cfg_vbytes);
		words = (b + 7) / 8;
		if (asm_pos >= words)
			asm_pos = 0;
		if (asm_pos + 1 < words) begin
			asm_buf[asm_pos] = d;
			asm_pos++;
			return;
		end
		rem  = b % 8;
		word = d;
		if (rem != 0)
			word = d & ((64'd1 << (8 * rem)) - 64'd1);
		asm_buf[asm_pos] = word;
		for (w = words; w < NW; w++)
			asm_buf[w] = '0;
		asm_pos = 0;
		found   = 1'b0;
		r       = '0;
		for (j = 0; j < tbl_cnt && !found; j++) begin
			same = 1'b1;
			for (w = 0; w < words && same; w++)
				if (uniq_tbl[j][w] != asm_buf[w])
					same = 1'b0;
			if (same) begin
				found = 1'b1;
				r     = '{index: j[vdi_pkg::INDEX_W-1:0], fresh: 1'b0, overflow: 1'b0};
			end
		end
		if (!found) begin
			if (tbl_cnt >= NU) begin
				r = '{index: '0, fresh: 1'b0, overflow: 1'b1};
			end else begin
				for (w = 0; w < NW; w++)
					uniq_tbl[tbl_cnt][w] = asm_buf[w];
				r = '{index: tbl_cnt[vdi_pkg::INDEX_W-1:0], fresh: 1'b1, overflow: 1'b0};
				tbl_cnt++;
			end
		end
		weld_add(r);
	endfunction

	// Driver: next item from the feed queue, random sender gaps and receiver stalls
	always @(negedge clk) begin : drive
		feed_t nxt;
		logic  v_next;
		if (arst_n) begin
			out_stall <= ($urandom_range(99) < stall_pct);
			v_next = in_valid && !in_taken;
			if (!v_next && chunk_feed.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = chunk_feed.pop_front();
				kind  <= nxt.kind_bit;
				chunk <= nxt.data;
				v_next = 1'b1;
			end
			in_valid <= v_next;
		end
	end

	// Monitor: predict on input transfers, check output transfers, watchdog
	always @(posedge clk) begin : observe
		weld_t got, want;
		bit    out_taken;
		in_taken  = arst_n && in_valid && !in_stall;
		out_taken = arst_n && out_valid && !out_stall;
		if (arst_n) begin
			if (in_taken) begin
				weld_vertex_item(kind, chunk);
				n_taken++;
			end
			if (out_taken) begin
				got = '{index: vertex_index, fresh: is_new, overflow: table_full};
				if (expected_welds.size() == 0) begin
					$display("%0t: unexpected result index %0d is_new %0b table_full %0b",
						$time, got.index, got.fresh, got.overflow);
					n_fail++;
				end else begin
					want = expected_welds.pop_front();
					n_checked++;
					if (got.index !== want.index) begin
						$display("%0t: vertex_index expected %0d actual %0d",
							$time, want.index, got.index);
						n_fail++;
					end
					if (got.fresh !== want.fresh) begin
						$display("%0t: is_new expected %0b actual %0b",
							$time, want.fresh, got.fresh);
						n_fail++;
					end
					if (got.overflow !== want.overflow) begin
						$display("%0t: table_full expected %0b actual %0b",
							$time, want.overflow, got.overflow);
						n_fail++;
					end
					if (want.overflow)
						n_full++;
					else if (want.fresh)
						n_new++;
					else
						n_hit++;
				end
			end
			if (in_taken || out_taken)
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, quiet);
				$display("tb failed");
				$finish;
			end
		end
	end

	// Read the size register back over the APB port
	task automatic check_vertex_bytes_reg();
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= VB_ADDR;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== {{(vdi_pkg::APB_DW - VBW){1'b0}}, cfg_vbytes}) begin
			$display("%0t: vertex_bytes readback expected %0d actual %0d",
				$time, cfg_vbytes, prdata);
			n_fail++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Write the size register (upper data bits random) and read it back
	task automatic set_vertex_bytes(input logic [VBW-1:0] val);
		logic [vdi_pkg::APB_DW-1:0] wd;
		wd = $urandom;
		wd[VBW-1:0] = val;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= VB_ADDR;
		pwdata  <= wd;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cfg_vbytes = val;
		asm_pos    = 0;
		size_now   = val;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		check_vertex_bytes_reg();
	endtask

	// Wait for the feed to empty and every weld result to arrive
	task automatic drain();
		while (chunk_feed.size() != 0 || in_valid)
			@(posedge clk);
		while (expected_welds.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic queue_vertex(input logic [511:0] v, input int words);
		for (int w = 0; w < words; w++)
			feed_add('{kind_bit: vdi_pkg::KIND_CHUNK, data: v[64*w +: 64]});
	endtask

	task automatic queue_start(input logic [vdi_pkg::CHUNK_W-1:0] d);
		feed_add('{kind_bit: vdi_pkg::KIND_START, data: d});
	endtask

	function automatic logic [511:0] rand_vertex();
		logic [511:0] v;
		int sel;
		sel = $urandom_range(19);
		if (sel == 0)
			v = '0;
		else if (sel == 1)
			v = '1;
		else
			for (int w = 0; w < 8; w++)
				v[64*w +: 64] = {$urandom, $urandom};
		return v;
	endfunction

	// Mostly whole vertices, many repeated or nearly repeated, plus stray chunks and starts
	task automatic random_burst(input int min_items, input int min_vtx);
		logic [511:0] pool[$];
		logic [511:0] v;
		int n_items, n_vtx, r, b, words, bitpos;
		n_items = 0;
		n_vtx   = 0;
		b       = eff_bytes(size_now);
		words   = (b + 7) / 8;
		while (n_items < min_items || n_vtx < min_vtx) begin
			r = $urandom_range(99);
			if (r < 4) begin
				queue_start({$urandom, $urandom});
				n_items++;
			end else if (r < 9) begin
				feed_add('{kind_bit: vdi_pkg::KIND_CHUNK, data: {$urandom, $urandom}});
				n_items++;
			end else begin
				if (pool.size() != 0 && r < 55) begin
					v = pool[$urandom_range(pool.size() - 1)];
					if (r < 25) begin
						// near miss inside the vertex
						bitpos = $urandom_range(8 * b - 1);
						v[bitpos] = ~v[bitpos];
					end else if (r < 35) begin
						// may land in the cleared high bytes: still a hit
						bitpos = $urandom_range(511);
						v[bitpos] = ~v[bitpos];
					end
				end else begin
					v = rand_vertex();
					pool = {pool, v};
				end
				queue_vertex(v, words);
				n_items += words;
				n_vtx++;
			end
		end
	endtask

	initial begin : stimulus
		logic [VBW-1:0] phase_size [4];
		int phase_idle [4];
		int phase_stall [4];
		logic [vdi_pkg::CHUNK_W-1:0] w64;
		logic [511:0] v;
		phase_size  = '{7'd8, 7'd1, 7'd20, 7'd64};
		phase_idle  = '{0, 79, 0, 17};
		phase_stall = '{0, 0, 79, 17};

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		check_vertex_bytes_reg();

		// Directed: default 32-byte vertices, hit, miss, start clears the table
		queue_vertex('0, 4);
		queue_vertex('0, 4);
		queue_vertex('1, 4);
		queue_start('1);
		queue_vertex('1, 4);
		drain();
		// size zero acts as one byte: high bytes cleared before the search
		set_vertex_bytes(7'd0);
		feed_add('{kind_bit: vdi_pkg::KIND_CHUNK, data: '1});
		feed_add('{kind_bit: vdi_pkg::KIND_CHUNK, data: 64'hFF});
		drain();
		// oversize clamps to the widest vertex; leave a partial vertex behind
		set_vertex_bytes(7'd127);
		queue_vertex(rand_vertex(), 8);
		queue_vertex(rand_vertex(), 3);
		drain();
		// register write drops the partial vertex; 9 bytes keeps one byte of word 1
		set_vertex_bytes(7'd9);
		queue_vertex('1, 2);
		drain();

		// Random phases with different idling patterns and sizes
		for (int p = 0; p < 4; p++) begin
			idle_pct  = phase_idle[p];
			stall_pct = phase_stall[p];
			set_vertex_bytes(phase_size[p]);
			random_burst(5, 1);
			drain();
			set_vertex_bytes(VBW'($urandom_range(127)));
			random_burst(5, 1);
			drain();
		end

		// One-word vertex stored, then widened to 64 bytes: words past the old size read as zero
		idle_pct  = 0;
		stall_pct = 0;
		set_vertex_bytes(7'd8);
		queue_start('0);
		w64 = {$urandom, $urandom};
		feed_add('{kind_bit: vdi_pkg::KIND_CHUNK, data: w64});
		drain();
		set_vertex_bytes(7'd64);
		queue_vertex({448'd0, w64}, 8);
		v = rand_vertex();
		v[64 +: 64] = '1;
		queue_vertex(v, 8);
		drain();
		set_vertex_bytes(vdi_pkg::VB_RESET);
		queue_start({$urandom, $urandom});
		queue_vertex(rand_vertex(), 4);
		drain();

		$display("Checked %0d results from %0d accepted items:", n_checked, n_taken);
		$display("%0d appended, %0d matched, %0d overflow; sizes 0 to 127 bytes, %s",
			n_new, n_hit, n_full, "four sender and receiver idling patterns.");
		if (n_fail == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
